@@ rtl/phase_field_lbm_d3q7_collide_macros.svh @@
// Assertion macros shared by the collide block.
`ifndef PHASE_FIELD_LBM_D3Q7_COLLIDE_MACROS_SVH
`define PHASE_FIELD_LBM_D3Q7_COLLIDE_MACROS_SVH
`ifndef SYNTHESIS
`define PFLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pflc assertion failed");
`define PFLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pflc assertion failed");
`else
`define PFLC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PFLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/pflc_pkg.sv @@
package pflc_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 28;
	localparam int RELAX_BITS = 30;
	localparam int GAIN_BITS  = 29;
	localparam int DATA_BITS  = 32;
	localparam int SQ_BITS    = 2 * WORD_BITS;
	localparam int ROOT_BITS  = WORD_BITS;
	localparam int NORM_BITS  = ROOT_BITS + 1;
	localparam int REM_BITS   = NORM_BITS + 1;
	localparam int QUO_BITS   = FRAC_BITS;
	localparam int PROD_BITS  = 2 * WORD_BITS + 1;
	localparam int QW         = PROD_BITS - FRAC_BITS;
	localparam int FRONT_LAT  = 6;
	localparam int BACK_LAT   = 4;
	localparam int LATENCY    = FRONT_LAT + ROOT_BITS + QUO_BITS + 1 + BACK_LAT;

	typedef logic signed [WORD_BITS-1:0] word_t;

	localparam word_t WMAX    = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WMIN    = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t ONE     = word_t'(longint'(1) << FRAC_BITS);
	localparam word_t NEG_ONE = -ONE;
	localparam word_t W4      = ONE >>> 2;
	localparam word_t W8      = ONE >>> 3;

	localparam logic [RELAX_BITS-1:0] RELAX_RESET = RELAX_BITS'(532610032);
	localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = GAIN_BITS'(1431656);

	typedef enum logic [0:0] {
		REG_RELAX = 1'b0,
		REG_GAIN  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		word_t pop_rest;
		word_t pop_xp;
		word_t pop_xm;
		word_t pop_yp;
		word_t pop_ym;
		word_t pop_zp;
		word_t pop_zm;
		word_t vel_x;
		word_t vel_y;
		word_t vel_z;
	} cell_t;

	typedef struct packed {
		word_t phase_out;
		word_t post_rest;
		word_t post_xp;
		word_t post_xm;
		word_t post_yp;
		word_t post_ym;
		word_t post_zp;
		word_t post_zm;
		logic  overspeed;
	} result_t;

	typedef struct packed {
		word_t       phi;
		logic        over;
		word_t [6:0] f;
		word_t [6:0] eq;
		word_t       sg;
		word_t [2:0] m;
	} side_t;

	function automatic word_t sat_add(word_t a, word_t b);
		logic [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			return s[WORD_BITS] ? WMIN : WMAX;
		end
		return word_t'(s[WORD_BITS-1:0]);
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b);
		logic [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			return s[WORD_BITS] ? WMIN : WMAX;
		end
		return word_t'(s[WORD_BITS-1:0]);
	endfunction

	function automatic word_t sat_neg(word_t a);
		return (a == WMIN) ? WMAX : -a;
	endfunction

	function automatic logic [WORD_BITS-1:0] mag(word_t a);
		return a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
	endfunction

	// round magnitude to nearest, halves away from zero, then saturate
	function automatic word_t mul_q(word_t a, word_t b);
		logic                 neg;
		logic [PROD_BITS-1:0] p;
		logic [PROD_BITS-1:0] half;
		logic [QW-1:0]        q;
		logic                 big;
		neg  = a[WORD_BITS-1] ^ b[WORD_BITS-1];
		half = '0;
		half[FRAC_BITS-1] = 1'b1;
		p = ({{(WORD_BITS+1){1'b0}}, mag(a)} * {{(WORD_BITS+1){1'b0}}, mag(b)}) + half;
		q   = p[PROD_BITS-1:FRAC_BITS];
		big = |q[QW-1:WORD_BITS-1];
		if (neg) begin
			return big ? WMIN : -word_t'(q[WORD_BITS-1:0]);
		end
		return big ? WMAX : word_t'(q[WORD_BITS-1:0]);
	endfunction

endpackage

@@ rtl/pflc_front.sv @@
module pflc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  pflc_pkg::cell_t                     site,
	input  logic [pflc_pkg::GAIN_BITS-1:0]      gain,
	output logic                                vld,
	output logic [pflc_pkg::SQ_BITS-1:0]        sq_sum,
	output pflc_pkg::side_t                     side
);

	localparam int W = pflc_pkg::WORD_BITS;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	pflc_pkg::word_t f_s1 [7];
	pflc_pkg::word_t u_s1 [3];
	pflc_pkg::word_t psum_s1;

	pflc_pkg::word_t f_s2 [7];
	pflc_pkg::word_t u_s2 [3];
	pflc_pkg::word_t phi_s2;
	pflc_pkg::word_t d_s2 [3];
	pflc_pkg::word_t ua_s2 [7];
	logic            over_s2;

	pflc_pkg::word_t f_s3 [7];
	pflc_pkg::word_t phi_s3;
	pflc_pkg::word_t d_s3 [3];
	pflc_pkg::word_t pu_s3 [3];
	pflc_pkg::word_t s_s3;
	pflc_pkg::word_t eq1_s3 [7];
	logic            over_s3;

	pflc_pkg::word_t f_s4 [7];
	pflc_pkg::word_t phi_s4;
	pflc_pkg::word_t m_s4 [3];
	pflc_pkg::word_t eq_s4 [7];
	pflc_pkg::word_t sw_s4;
	logic            over_s4;

	pflc_pkg::word_t f_s5 [7];
	pflc_pkg::word_t phi_s5;
	pflc_pkg::word_t m_s5 [3];
	pflc_pkg::word_t eq_s5 [7];
	pflc_pkg::word_t sg_s5;
	logic [2*W-1:0]  sqm_s5 [3];
	logic            over_s5;

	logic [pflc_pkg::SQ_BITS-1:0] sum_s6;
	pflc_pkg::side_t              side_s6;

	pflc_pkg::word_t psum_d;
	pflc_pkg::word_t phi_d;
	pflc_pkg::word_t ua_d [7];
	logic            over_d;
	pflc_pkg::word_t gain_w;

	always_comb begin
		pflc_pkg::word_t cu;
		pflc_pkg::word_t a;
		psum_d = pflc_pkg::sat_add(pflc_pkg::sat_add(pflc_pkg::sat_add(
			site.pop_rest, site.pop_xp), site.pop_xm), site.pop_yp);
		phi_d = pflc_pkg::sat_add(pflc_pkg::sat_add(pflc_pkg::sat_add(
			psum_s1, f_s1[4]), f_s1[5]), f_s1[6]);
		ua_d[0] = pflc_pkg::ONE;
		for (int k = 1; k < 7; k++) begin
			cu = (k % 2 == 1) ? u_s1[(k-1) >> 1] : pflc_pkg::sat_neg(u_s1[(k-1) >> 1]);
			a  = pflc_pkg::sat_add(cu, cu);
			a  = pflc_pkg::sat_add(a, a);
			ua_d[k] = pflc_pkg::sat_add(pflc_pkg::ONE, a);
		end
		over_d = (u_s1[0] > pflc_pkg::ONE) || (u_s1[0] < pflc_pkg::NEG_ONE);
		gain_w = pflc_pkg::word_t'({{(W-pflc_pkg::GAIN_BITS){1'b0}}, gain});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		f_s1[0] <= site.pop_rest;
		f_s1[1] <= site.pop_xp;
		f_s1[2] <= site.pop_xm;
		f_s1[3] <= site.pop_yp;
		f_s1[4] <= site.pop_ym;
		f_s1[5] <= site.pop_zp;
		f_s1[6] <= site.pop_zm;
		u_s1[0] <= site.vel_x;
		u_s1[1] <= site.vel_y;
		u_s1[2] <= site.vel_z;
		psum_s1 <= psum_d;

		f_s2    <= f_s1;
		u_s2    <= u_s1;
		phi_s2  <= phi_d;
		ua_s2   <= ua_d;
		over_s2 <= over_d;
		for (int k = 0; k < 3; k++) begin
			d_s2[k] <= pflc_pkg::sat_sub(f_s1[2*k+1], f_s1[2*k+2]);
		end

		f_s3    <= f_s2;
		phi_s3  <= phi_s2;
		d_s3    <= d_s2;
		over_s3 <= over_s2;
		s_s3    <= pflc_pkg::mul_q(phi_s2, pflc_pkg::sat_sub(pflc_pkg::ONE, phi_s2));
		for (int k = 0; k < 3; k++) begin
			pu_s3[k] <= pflc_pkg::mul_q(phi_s2, u_s2[k]);
		end
		for (int k = 0; k < 7; k++) begin
			eq1_s3[k] <= pflc_pkg::mul_q(phi_s2, ua_s2[k]);
		end

		f_s4    <= f_s3;
		phi_s4  <= phi_s3;
		over_s4 <= over_s3;
		sw_s4   <= pflc_pkg::mul_q(s_s3, pflc_pkg::W8);
		for (int k = 0; k < 3; k++) begin
			m_s4[k] <= pflc_pkg::sat_sub(d_s3[k], pu_s3[k]);
		end
		for (int k = 0; k < 7; k++) begin
			eq_s4[k] <= pflc_pkg::mul_q(eq1_s3[k], (k == 0) ? pflc_pkg::W4 : pflc_pkg::W8);
		end

		f_s5    <= f_s4;
		phi_s5  <= phi_s4;
		m_s5    <= m_s4;
		eq_s5   <= eq_s4;
		over_s5 <= over_s4;
		sg_s5   <= pflc_pkg::mul_q(sw_s4, gain_w);
		for (int k = 0; k < 3; k++) begin
			sqm_s5[k] <= {{W{1'b0}}, pflc_pkg::mag(m_s4[k])}
				* {{W{1'b0}}, pflc_pkg::mag(m_s4[k])};
		end

		sum_s6       <= sqm_s5[0] + sqm_s5[1] + sqm_s5[2];
		side_s6.phi  <= phi_s5;
		side_s6.over <= over_s5;
		side_s6.sg   <= sg_s5;
		for (int k = 0; k < 7; k++) begin
			side_s6.f[k]  <= f_s5[k];
			side_s6.eq[k] <= eq_s5[k];
		end
		for (int k = 0; k < 3; k++) begin
			side_s6.m[k] <= m_s5[k];
		end
	end

	assign vld    = vld_s6;
	assign sq_sum = sum_s6;
	assign side   = side_s6;

endmodule

@@ rtl/pflc_isqrt.sv @@
module pflc_isqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic [pflc_pkg::SQ_BITS-1:0]        x,
	input  pflc_pkg::side_t                     side_in,
	output logic                                out_vld,
	output logic [pflc_pkg::NORM_BITS-1:0]      norm,
	output pflc_pkg::side_t                     side_out
);

	localparam int N  = pflc_pkg::ROOT_BITS;
	localparam int XB = pflc_pkg::SQ_BITS;
	localparam int TB = XB + 2;

	logic            vld_s  [1:N];
	logic [XB-1:0]   rem_s  [1:N];
	logic [N-1:0]    root_s [1:N];
	pflc_pkg::side_t side_s [1:N];

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam int BIT = N - 1 - g;
		logic            cur_vld;
		logic [XB-1:0]   cur_rem;
		logic [N-1:0]    cur_root;
		pflc_pkg::side_t cur_side;
		logic [TB-1:0]   trial;
		logic            ge;

		if (g == 0) begin : g_head
			assign cur_vld  = in_vld;
			assign cur_rem  = x;
			assign cur_root = '0;
			assign cur_side = side_in;
		end else begin : g_body
			assign cur_vld  = vld_s[g];
			assign cur_rem  = rem_s[g];
			assign cur_root = root_s[g];
			assign cur_side = side_s[g];
		end

		assign trial = ({{(TB-N){1'b0}}, cur_root} << (BIT + 1)) + (TB'(1) << (2 * BIT));
		assign ge    = {2'b00, cur_rem} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= ge ? (cur_rem - trial[XB-1:0]) : cur_rem;
			root_s[g+1] <= ge ? (cur_root | (N'(1) << BIT)) : cur_root;
			side_s[g+1] <= cur_side;
		end
	end

	assign out_vld  = vld_s[N];
	assign norm     = {1'b0, root_s[N]} + pflc_pkg::NORM_BITS'(1);
	assign side_out = side_s[N];

endmodule

@@ rtl/pflc_ndiv.sv @@
`include "phase_field_lbm_d3q7_collide_macros.svh"

module pflc_ndiv (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic [pflc_pkg::NORM_BITS-1:0]      norm,
	input  pflc_pkg::side_t                     side_in,
	output logic                                out_vld,
	output pflc_pkg::word_t [2:0]               n,
	output pflc_pkg::side_t                     side_out
);

	localparam int Q  = pflc_pkg::QUO_BITS;
	localparam int RB = pflc_pkg::REM_BITS;
	localparam int NB = pflc_pkg::NORM_BITS;
	localparam int W  = pflc_pkg::WORD_BITS;

	logic                  vld_s  [1:Q];
	logic [2:0][RB-1:0]    rem_s  [1:Q];
	logic [2:0][Q-1:0]     quo_s  [1:Q];
	logic [NB-1:0]         norm_s [1:Q];
	pflc_pkg::side_t       side_s [1:Q];

	logic                  vld_sr;
	pflc_pkg::word_t       n_sr [3];
	pflc_pkg::side_t       side_sr;
	pflc_pkg::word_t       n_d  [3];

	for (genvar g = 0; g < Q; g++) begin : g_stage
		localparam int BIT = Q - 1 - g;
		logic               cur_vld;
		logic [NB-1:0]      cur_norm;
		pflc_pkg::side_t    cur_side;
		logic [2:0][RB-1:0] cur_rem;
		logic [2:0][Q-1:0]  cur_quo;
		logic [2:0][RB-1:0] nxt_rem;
		logic [2:0][Q-1:0]  nxt_quo;

		if (g == 0) begin : g_head
			always_comb begin
				cur_vld  = in_vld;
				cur_norm = norm;
				cur_side = side_in;
				for (int k = 0; k < 3; k++) begin
					cur_rem[k] = RB'(pflc_pkg::mag(side_in.m[k]));
					cur_quo[k] = '0;
				end
			end
		end else begin : g_body
			assign cur_vld  = vld_s[g];
			assign cur_norm = norm_s[g];
			assign cur_side = side_s[g];
			assign cur_rem  = rem_s[g];
			assign cur_quo  = quo_s[g];
		end

		always_comb begin
			logic [RB-1:0] sh;
			logic          ge;
			for (int k = 0; k < 3; k++) begin
				sh = cur_rem[k] << 1;
				ge = sh >= RB'(cur_norm);
				nxt_rem[k] = ge ? (sh - RB'(cur_norm)) : sh;
				nxt_quo[k] = cur_quo[k];
				nxt_quo[k][BIT] = ge;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= nxt_rem;
			quo_s[g+1]  <= nxt_quo;
			norm_s[g+1] <= cur_norm;
			side_s[g+1] <= cur_side;
		end
	end

	always_comb begin
		logic [RB-1:0]   r;
		logic [RB-1:0]   d;
		logic            up;
		logic [Q:0]      qr;
		pflc_pkg::word_t val;
		pflc_pkg::word_t mk;
		for (int k = 0; k < 3; k++) begin
			r   = rem_s[Q][k];
			d   = RB'(norm_s[Q]);
			up  = r >= (d - r);
			qr  = {1'b0, quo_s[Q][k]} + (Q+1)'(up);
			val = pflc_pkg::word_t'({{(W-Q-1){1'b0}}, qr});
			mk  = side_s[Q].m[k];
			n_d[k] = (!mk[W-1] && (|mk)) ? -val : val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
		end else begin
			vld_sr <= vld_s[Q];
		end
	end

	always_ff @(posedge clk) begin
		n_sr    <= n_d;
		side_sr <= side_s[Q];
	end

	assign out_vld  = vld_sr;
	assign n        = {n_sr[2], n_sr[1], n_sr[0]};
	assign side_out = side_sr;

	`PFLC_ASSERT_IMPL(a_normal_bound, clk, arst_n, vld_sr, (n_sr[0] <= pflc_pkg::ONE) && (n_sr[0] >= pflc_pkg::NEG_ONE) && (n_sr[1] <= pflc_pkg::ONE) && (n_sr[1] >= pflc_pkg::NEG_ONE) && (n_sr[2] <= pflc_pkg::ONE) && (n_sr[2] >= pflc_pkg::NEG_ONE))

endmodule

@@ rtl/pflc_back.sv @@
module pflc_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  pflc_pkg::word_t [2:0]               n,
	input  pflc_pkg::side_t                     side,
	input  logic [pflc_pkg::RELAX_BITS-1:0]     relax,
	output logic                                done,
	output pflc_pkg::result_t                   result
);

	localparam int W = pflc_pkg::WORD_BITS;

	logic              vld_s1, vld_s2, vld_s3, done_s4;
	pflc_pkg::side_t   side_s1, side_s2, side_s3;
	pflc_pkg::word_t   sh_s1   [7];
	pflc_pkg::word_t   diff_s2 [7];
	pflc_pkg::word_t   rel_s3  [7];
	pflc_pkg::result_t result_s4;
	pflc_pkg::word_t   omega_w;
	pflc_pkg::word_t   sh_d    [7];
	pflc_pkg::word_t   post_d  [7];

	always_comb begin
		pflc_pkg::word_t nk;
		pflc_pkg::word_t cn;
		omega_w = pflc_pkg::word_t'({{(W-pflc_pkg::RELAX_BITS){1'b0}}, relax});
		sh_d[0] = '0;
		for (int k = 1; k < 7; k++) begin
			nk = n[(k-1) >> 1];
			cn = (k % 2 == 1) ? nk : pflc_pkg::sat_neg(nk);
			sh_d[k] = pflc_pkg::mul_q(side.sg, cn);
		end
		for (int k = 0; k < 7; k++) begin
			post_d[k] = pflc_pkg::sat_add(side_s3.f[k], rel_s3[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			done_s4 <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			done_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side;
		sh_s1   <= sh_d;
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		for (int k = 0; k < 7; k++) begin
			diff_s2[k] <= pflc_pkg::sat_sub(
				pflc_pkg::sat_add(side_s1.eq[k], sh_s1[k]), side_s1.f[k]);
			rel_s3[k]  <= pflc_pkg::mul_q(omega_w, diff_s2[k]);
		end
		result_s4.phase_out <= side_s3.phi;
		result_s4.post_rest <= post_d[0];
		result_s4.post_xp   <= post_d[1];
		result_s4.post_xm   <= post_d[2];
		result_s4.post_yp   <= post_d[3];
		result_s4.post_ym   <= post_d[4];
		result_s4.post_zp   <= post_d[5];
		result_s4.post_zm   <= post_d[6];
		result_s4.overspeed <= side_s3.over;
	end

	assign done   = done_s4;
	assign result = result_s4;

endmodule

@@ rtl/phase_field_lbm_d3q7_collide.sv @@
// D3Q7 phase-field collision, one cell per beat. A cell can start in every
// clock cycle and busy stays low; its result appears with done after passing
// through the pipeline (6 front stages, 32 square-root stages for the
// gradient norm, 28 quotient stages plus one rounding stage for the normal,
// 4 relaxation stages). The receiver cannot stall: done is a one-cycle
// strobe and results leave in start order. Write relax_rate and
// sharpen_gain only while no cell is in flight.
`include "phase_field_lbm_d3q7_collide_macros.svh"

module phase_field_lbm_d3q7_collide (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  pflc_pkg::cell_t                     site,
	output logic                                done,
	output pflc_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  pflc_pkg::reg_idx_t                  cfg_index,
	input  logic [pflc_pkg::DATA_BITS-1:0]      cfg_data
);

	logic [pflc_pkg::RELAX_BITS-1:0] relax_q;
	logic [pflc_pkg::GAIN_BITS-1:0]  gain_q;

	logic                            fr_vld;
	logic [pflc_pkg::SQ_BITS-1:0]    fr_sum;
	pflc_pkg::side_t                 fr_side;
	logic                            sq_vld;
	logic [pflc_pkg::NORM_BITS-1:0]  sq_norm;
	pflc_pkg::side_t                 sq_side;
	logic                            dv_vld;
	pflc_pkg::word_t [2:0]           dv_n;
	pflc_pkg::side_t                 dv_side;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= pflc_pkg::RELAX_RESET;
			gain_q  <= pflc_pkg::GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pflc_pkg::REG_RELAX: relax_q <= cfg_data[pflc_pkg::RELAX_BITS-1:0];
				pflc_pkg::REG_GAIN:  gain_q  <= cfg_data[pflc_pkg::GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	pflc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !busy),
		.site   (site),
		.gain   (gain_q),
		.vld    (fr_vld),
		.sq_sum (fr_sum),
		.side   (fr_side)
	);

	pflc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (fr_vld),
		.x        (fr_sum),
		.side_in  (fr_side),
		.out_vld  (sq_vld),
		.norm     (sq_norm),
		.side_out (sq_side)
	);

	pflc_ndiv u_ndiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.norm     (sq_norm),
		.side_in  (sq_side),
		.out_vld  (dv_vld),
		.n        (dv_n),
		.side_out (dv_side)
	);

	pflc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (dv_vld),
		.n      (dv_n),
		.side   (dv_side),
		.relax  (relax_q),
		.done   (done),
		.result (result)
	);

	`PFLC_ASSERT_IMPL(a_start_to_done, clk, arst_n, start && !busy, ##71 done)
	`PFLC_ASSERT_IMPL(a_done_has_start, clk, arst_n, done, $past(start && !busy, pflc_pkg::LATENCY))
	`PFLC_ASSERT_NEXT(a_cfg_relax, clk, arst_n, cfg_valid && cfg_ready && cfg_index == pflc_pkg::REG_RELAX, relax_q == $past(cfg_data[pflc_pkg::RELAX_BITS-1:0]))
	`PFLC_ASSERT_NEXT(a_cfg_gain, clk, arst_n, cfg_valid && cfg_ready && cfg_index == pflc_pkg::REG_GAIN, gain_q == $past(cfg_data[pflc_pkg::GAIN_BITS-1:0]))

endmodule

@@ tb/sv/phase_field_lbm_d3q7_collide_tb.sv @@
`timescale 1ns / 1ps

module phase_field_lbm_d3q7_collide_tb;
	import pflc_pkg::*;

	localparam int WB = WORD_BITS;
	localparam int FB = FRAC_BITS;
	localparam int IDLE_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cell_t site;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	reg_idx_t cfg_index;
	logic [DATA_BITS-1:0] cfg_data;

	phase_field_lbm_d3q7_collide u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .site(site),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [RELAX_BITS-1:0] omega_q;
	logic [GAIN_BITS-1:0] gain_q;

	cell_t pending_cells[$];
	result_t collide_expect[$];
	int send_idle_pct;
	bit hold_send;
	bit running;
	int errors;
	int idle_cycles;
	int cells_sent;
	int results_seen;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [WB-1:0] magn(logic signed [WB-1:0] a);
		return a[WB-1] ? -a : a;
	endfunction

	function automatic logic signed [WB-1:0] fx_add(logic signed [WB-1:0] a,
			logic signed [WB-1:0] b);
		logic signed [WB:0] s;
		s = a + b;
		if (s > $signed({2'b00, {(WB-1){1'b1}}})) return {1'b0, {(WB-1){1'b1}}};
		if (s < -$signed({2'b01, {(WB-1){1'b0}}})) return {1'b1, {(WB-1){1'b0}}};
		return s[WB-1:0];
	endfunction

	function automatic logic signed [WB-1:0] fx_sub(logic signed [WB-1:0] a,
			logic signed [WB-1:0] b);
		logic signed [WB:0] s;
		s = a - b;
		if (s > $signed({2'b00, {(WB-1){1'b1}}})) return {1'b0, {(WB-1){1'b1}}};
		if (s < -$signed({2'b01, {(WB-1){1'b0}}})) return {1'b1, {(WB-1){1'b0}}};
		return s[WB-1:0];
	endfunction

	function automatic logic signed [WB-1:0] fx_neg(logic signed [WB-1:0] a);
		return (a == {1'b1, {(WB-1){1'b0}}}) ? {1'b0, {(WB-1){1'b1}}} : -a;
	endfunction

	function automatic logic signed [WB-1:0] fx_mul(logic signed [WB-1:0] a,
			logic signed [WB-1:0] b);
		logic [2*WB+1:0] p;
		logic [2*WB+1:0] q;
		p = {{(WB+2){1'b0}}, magn(a)} * {{(WB+2){1'b0}}, magn(b)};
		p = p + ({{(2*WB+1){1'b0}}, 1'b1} << (FB - 1));
		q = p >> FB;
		if (a[WB-1] ^ b[WB-1]) begin
			if (q > (2*WB+2)'({1'b0, {(WB-1){1'b1}}})) return {1'b1, {(WB-1){1'b0}}};
			return -q[WB-1:0];
		end
		if (q > (2*WB+2)'({1'b0, {(WB-1){1'b1}}})) return {1'b0, {(WB-1){1'b1}}};
		return q[WB-1:0];
	endfunction

	function automatic logic [WB+1:0] root_floor(logic [2*WB+1:0] x);
		logic [WB+1:0] r;
		logic [WB+1:0] c;
		r = '0;
		for (int b = WB + 1; b >= 0; b--) begin
			c = r | ((WB+2)'(1) << b);
			if ({{(WB+2){1'b0}}, c} * {{(WB+2){1'b0}}, c} <= {{(WB+2){1'b0}}, x}) r = c;
		end
		return r;
	endfunction

	function automatic logic signed [WB-1:0] unit_comp(logic signed [WB-1:0] k,
			logic [WB+1:0] d);
		logic [2*WB+FB:0] num;
		logic [2*WB+FB:0] q;
		logic [2*WB+FB:0] r;
		num = {{(WB+FB+1){1'b0}}, magn(k)} << FB;
		q = num / d;
		r = num % d;
		if (r >= d - r) q = q + 1;
		return k > 0 ? -q[WB-1:0] : q[WB-1:0];
	endfunction

	function automatic result_t collide_cell(cell_t c);
		logic signed [WB-1:0] f[7];
		logic signed [WB-1:0] u[3];
		logic signed [WB-1:0] m[3];
		logic signed [WB-1:0] n[3];
		logic signed [WB-1:0] phi, s, wf, cu, cn, a, eq, sh, g, omega, gain;
		logic signed [WB-1:0] post[7];
		logic [2*WB+1:0] sq;
		logic [WB+1:0] norm;
		int ax;
		result_t r;
		f = '{c.pop_rest, c.pop_xp, c.pop_xm, c.pop_yp, c.pop_ym, c.pop_zp, c.pop_zm};
		u = '{c.vel_x, c.vel_y, c.vel_z};
		omega = WB'(omega_q);
		gain = WB'(gain_q);
		phi = '0;
		for (int k = 0; k < 7; k++) phi = fx_add(phi, f[k]);
		sq = '0;
		for (int k = 0; k < 3; k++) begin
			m[k] = fx_sub(fx_sub(f[1 + 2 * k], f[2 + 2 * k]), fx_mul(phi, u[k]));
			sq = sq + {{(WB+2){1'b0}}, magn(m[k])} * {{(WB+2){1'b0}}, magn(m[k])};
		end
		norm = root_floor(sq) + 1;
		for (int k = 0; k < 3; k++) n[k] = unit_comp(m[k], norm);
		s = fx_mul(phi, fx_sub(ONE, phi));
		for (int k = 0; k < 7; k++) begin
			wf = (k == 0) ? W4 : W8;
			cu = '0;
			cn = '0;
			if (k != 0) begin
				ax = (k - 1) / 2;
				cu = (k % 2 == 1) ? u[ax] : fx_neg(u[ax]);
				cn = (k % 2 == 1) ? n[ax] : fx_neg(n[ax]);
			end
			a = fx_add(cu, cu);
			a = fx_add(a, a);
			eq = fx_mul(fx_mul(phi, fx_add(ONE, a)), wf);
			sh = fx_mul(fx_mul(fx_mul(s, wf), gain), cn);
			g = fx_add(eq, sh);
			post[k] = fx_add(f[k], fx_mul(omega, fx_sub(g, f[k])));
		end
		r.phase_out = phi;
		r.post_rest = post[0];
		r.post_xp = post[1];
		r.post_xm = post[2];
		r.post_yp = post[3];
		r.post_ym = post[4];
		r.post_zp = post[5];
		r.post_zm = post[6];
		r.overspeed = (c.vel_x > ONE) || (c.vel_x < NEG_ONE);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			site <= '0;
		end else begin
			if (start && !busy) begin
				collide_expect.push_back(collide_cell(site));
				cells_sent++;
			end
			if (!(start && busy)) begin
				if (pending_cells.size() > 0 && !hold_send &&
						$urandom_range(99) >= send_idle_pct) begin
					start <= 1'b1;
					site <= pending_cells.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			result_t e;
			results_seen++;
			if (collide_expect.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = collide_expect.pop_front();
				if (result.phase_out !== e.phase_out) begin
					$error("phase_out exp %h got %h", e.phase_out, result.phase_out);
					errors++;
				end
				if (result.post_rest !== e.post_rest) begin
					$error("post_rest exp %h got %h", e.post_rest, result.post_rest);
					errors++;
				end
				if (result.post_xp !== e.post_xp) begin
					$error("post_xp exp %h got %h", e.post_xp, result.post_xp);
					errors++;
				end
				if (result.post_xm !== e.post_xm) begin
					$error("post_xm exp %h got %h", e.post_xm, result.post_xm);
					errors++;
				end
				if (result.post_yp !== e.post_yp) begin
					$error("post_yp exp %h got %h", e.post_yp, result.post_yp);
					errors++;
				end
				if (result.post_ym !== e.post_ym) begin
					$error("post_ym exp %h got %h", e.post_ym, result.post_ym);
					errors++;
				end
				if (result.post_zp !== e.post_zp) begin
					$error("post_zp exp %h got %h", e.post_zp, result.post_zp);
					errors++;
				end
				if (result.post_zm !== e.post_zm) begin
					$error("post_zm exp %h got %h", e.post_zm, result.post_zm);
					errors++;
				end
				if (result.overspeed !== e.overspeed) begin
					$error("overspeed exp %b got %b", e.overspeed, result.overspeed);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (running) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("phase_field_lbm_d3q7_collide: mismatch");
				$finish;
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_RELAX) omega_q = val[RELAX_BITS-1:0];
		else gain_q = val[GAIN_BITS-1:0];
		@(posedge clk);
	endtask

	task automatic drain_pipe();
		while (pending_cells.size() > 0 || start || collide_expect.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [WB-1:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom;
			1: return {1'b0, {(WB-1){1'b1}}} - $urandom_range(3);
			2: return {1'b1, {(WB-1){1'b0}}} + $urandom_range(3);
			default: return WB'($signed($urandom_range(2 * ONE))) - ONE / 2;
		endcase
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		logic signed [WB-1:0] phi;
		if ($urandom_range(9) < 7) begin
			phi = $urandom_range(ONE);
			c.pop_rest = phi / 4 + $signed($urandom_range(4096)) - 2048;
			c.pop_xp = phi / 8 + $signed($urandom_range(1 << 20)) - (1 << 19);
			c.pop_xm = phi / 8 + $signed($urandom_range(1 << 20)) - (1 << 19);
			c.pop_yp = phi / 8 + $signed($urandom_range(1 << 20)) - (1 << 19);
			c.pop_ym = phi / 8 + $signed($urandom_range(1 << 20)) - (1 << 19);
			c.pop_zp = phi / 8 + $signed($urandom_range(1 << 20)) - (1 << 19);
			c.pop_zm = phi / 8 + $signed($urandom_range(1 << 20)) - (1 << 19);
			c.vel_x = $signed($urandom_range(ONE / 4)) - ONE / 8;
			c.vel_y = $signed($urandom_range(ONE / 4)) - ONE / 8;
			c.vel_z = $signed($urandom_range(ONE / 4)) - ONE / 8;
			if ($urandom_range(9) == 0) c.vel_x = $signed($urandom_range(3 * ONE)) - ONE - ONE / 2;
		end else begin
			c = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
				rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
		end
		return c;
	endfunction

	task automatic queue_directed();
		cell_t c;
		pending_cells.push_back('0);
		pending_cells.push_back({10{WMAX}});
		pending_cells.push_back({10{WMIN}});
		pending_cells.push_back({10{32'hffff_ffff}});
		pending_cells.push_back({10{32'h5555_5555}});
		pending_cells.push_back({10{32'haaaa_aaaa}});
		c = '0;
		c.pop_rest = ONE;
		c.vel_x = ONE;
		pending_cells.push_back(c);
		c.vel_x = ONE + 1;
		pending_cells.push_back(c);
		c.vel_x = NEG_ONE;
		pending_cells.push_back(c);
		c.vel_x = NEG_ONE - 1;
		pending_cells.push_back(c);
		c = '0;
		c.pop_xp = ONE / 2;
		c.pop_rest = ONE / 4;
		pending_cells.push_back(c);
		c = '0;
		c.pop_yp = WMAX;
		c.pop_ym = WMIN;
		c.vel_y = WMIN;
		c.vel_z = WMAX;
		pending_cells.push_back(c);
		c = '0;
		c.pop_zm = ONE / 8;
		c.pop_zp = ONE / 8;
		c.vel_z = ONE / 16;
		pending_cells.push_back(c);
		for (int i = 0; i < 6; i++) pending_cells.push_back(rand_cell());
	endtask

	task automatic run_phase(int count, int idle_pct);
		send_idle_pct = idle_pct;
		for (int i = 0; i < count; i++) pending_cells.push_back(rand_cell());
		while (pending_cells.size() > 0) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		site = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RELAX;
		cfg_data = '0;
		omega_q = RELAX_RESET;
		gain_q = GAIN_RESET;
		hold_send = 1'b0;
		send_idle_pct = 0;
		errors = 0;
		idle_cycles = 0;
		cells_sent = 0;
		results_seen = 0;
		running = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1'b1;

		send_idle_pct = 7;
		queue_directed();
		run_phase(200, 7);
		hold_send = 1'b1;
		drain_pipe();
		hold_send = 1'b0;

		reg_write(REG_RELAX, 32'd536870912);
		reg_write(REG_GAIN, 32'd268435456);
		queue_directed();
		run_phase(200, 69);
		drain_pipe();

		reg_write(REG_RELAX, 32'd0);
		reg_write(REG_GAIN, 32'd0);
		run_phase(150, 0);
		drain_pipe();

		reg_write(REG_RELAX, 32'hffff_ffff);
		reg_write(REG_GAIN, 32'hffff_ffff);
		run_phase(150, 0);
		drain_pipe();

		for (int p = 0; p < 4; p++) begin
			reg_write(REG_RELAX, $urandom_range(536870912));
			reg_write(REG_GAIN, $urandom_range(268435456));
			run_phase(150, p % 2 == 0 ? 0 : 7);
			drain_pipe();
		end

		$display("Run covered %0d cells and %0d result beats over eight register settings,",
			cells_sent, results_seen);
		$display("  including both rate extremes, zero and all-ones register writes.");
		if (errors == 0 && collide_expect.size() == 0) begin
			$display("phase_field_lbm_d3q7_collide: match");
		end else begin
			$display("phase_field_lbm_d3q7_collide: mismatch");
		end
		$finish;
	end

endmodule

@@ phase_field_lbm_d3q7_collide.f @@
+incdir+rtl
rtl/pflc_pkg.sv
rtl/pflc_front.sv
rtl/pflc_isqrt.sv
rtl/pflc_ndiv.sv
rtl/pflc_back.sv
rtl/phase_field_lbm_d3q7_collide.sv
tb/sv/phase_field_lbm_d3q7_collide_tb.sv
